/* rtl/qcaq_pkg.sv */
// ----------------------------------------------------------------------------
// qcaq_pkg: shared types and constants of the quad corner angle quality unit
// Formats, pipeline depths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qcaq_pkg;

	localparam int COORD_W   = 16;              // signed Q8.8 coordinate
	localparam int QUAL_FRAC = 14;              // quality fraction bits
	localparam int QUAL_W    = QUAL_FRAC + 2;   // signed Q1.14
	localparam int EDGE_W    = COORD_W + 1;     // difference of two coordinates
	localparam int PROD_W    = 2 * EDGE_W;      // one component product
	localparam int SQ_W      = PROD_W + 1;      // sum of three squares
	localparam int DOT_W     = PROD_W + 2;      // signed sum of three products
	localparam int LEN_SHIFT = 26;
	localparam int RAD_W     = 62;              // radicand width
	localparam int ROOT_W    = RAD_W / 2;       // root width
	localparam int COS_FRAC  = 30;              // cosine in Q2.30
	localparam int COS_W     = COS_FRAC + 2;
	localparam int DIV_W     = 62;              // divider remainder width
	localparam int CORDIC_N  = 20;
	localparam int ANG_BITS  = 20;              // pi/2 = 2^20
	localparam int ANG_W     = ANG_BITS + 3;
	localparam int CX_W      = COS_W + 2;       // CORDIC x/y with gain headroom
	localparam int ROUND_SH  = ANG_BITS - QUAL_FRAC;

	localparam int SQRT_LAT  = ROOT_W;
	localparam int LANE_LAT  = 2 + SQRT_LAT;
	localparam int DIV_LAT   = 2 + COS_FRAC;
	localparam int ASIN_LAT  = 3 + SQRT_LAT + CORDIC_N;
	localparam int PIPE_LAT  = 1 + LANE_LAT + DIV_LAT + ASIN_LAT;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic [RAD_W-1:0]          rad_t;
	typedef logic [ROOT_W-1:0]         len_t;
	typedef logic signed [COS_W-1:0]   cos_t;
	typedef logic signed [QUAL_W-1:0]  qual_t;
	typedef logic signed [ANG_W-1:0]   ang_t;

	typedef struct packed {
		edge_t x;
		edge_t y;
		edge_t z;
	} vec_t;

	// atan(2^-i), pi/2 = 2^20
	function automatic ang_t atan_unit(input int i);
		ang_t a;
		unique case (i)
			0:  a = ANG_W'(524288);
			1:  a = ANG_W'(309505);
			2:  a = ANG_W'(163534);
			3:  a = ANG_W'(83012);
			4:  a = ANG_W'(41667);
			5:  a = ANG_W'(20854);
			6:  a = ANG_W'(10430);
			7:  a = ANG_W'(5215);
			8:  a = ANG_W'(2608);
			9:  a = ANG_W'(1304);
			10: a = ANG_W'(652);
			11: a = ANG_W'(326);
			12: a = ANG_W'(163);
			13: a = ANG_W'(81);
			14: a = ANG_W'(41);
			15: a = ANG_W'(20);
			16: a = ANG_W'(10);
			17: a = ANG_W'(5);
			18: a = ANG_W'(3);
			19: a = ANG_W'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

/* rtl/qcaq_quad_if.sv */
// ----------------------------------------------------------------------------
// qcaq_quad_if: quad input channel
// Valid/ready channel carrying the twelve corner coordinates of one quad.
// ----------------------------------------------------------------------------
interface qcaq_quad_if import qcaq_pkg::*;;
	logic   valid;
	logic   ready;
	coord_t corner_a_x;
	coord_t corner_a_y;
	coord_t corner_a_z;
	coord_t corner_b_x;
	coord_t corner_b_y;
	coord_t corner_b_z;
	coord_t corner_c_x;
	coord_t corner_c_y;
	coord_t corner_c_z;
	coord_t corner_d_x;
	coord_t corner_d_y;
	coord_t corner_d_z;

	modport source(output valid, output corner_a_x, output corner_a_y, output corner_a_z,
		output corner_b_x, output corner_b_y, output corner_b_z,
		output corner_c_x, output corner_c_y, output corner_c_z,
		output corner_d_x, output corner_d_y, output corner_d_z, input ready);
	modport sink(input valid, input corner_a_x, input corner_a_y, input corner_a_z,
		input corner_b_x, input corner_b_y, input corner_b_z,
		input corner_c_x, input corner_c_y, input corner_c_z,
		input corner_d_x, input corner_d_y, input corner_d_z, output ready);
endinterface

/* rtl/qcaq_result_if.sv */
// ----------------------------------------------------------------------------
// qcaq_result_if: quality result channel
// Valid/ready channel carrying the quality word and the degenerate flag.
// ----------------------------------------------------------------------------
interface qcaq_result_if import qcaq_pkg::*;;
	logic  valid;
	logic  ready;
	qual_t quality;
	logic  degenerate;

	modport source(output valid, output quality, output degenerate, input ready);
	modport sink(input valid, input quality, input degenerate, output ready);
endinterface

/* rtl/qcaq_isqrt.sv */
// ----------------------------------------------------------------------------
// qcaq_isqrt: pipelined integer square root
// One root bit per stage, remainder form, floor result.
// ----------------------------------------------------------------------------
module qcaq_isqrt import qcaq_pkg::*; (
	input  logic clk,
	input  logic en,
	input  rad_t rad,
	output len_t root
);
	rad_t rem_q  [ROOT_W];
	len_t root_q [ROOT_W];

	for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
		localparam int B = ROOT_W - 1 - s;
		rad_t           rin;
		len_t           qin;
		logic [RAD_W:0] trial;

		if (s == 0) begin : g_first
			assign rin = rad;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_q[s-1];
			assign qin = root_q[s-1];
		end

		assign trial = ({(RAD_W + 1 - ROOT_W)'(0), qin} << (B + 1))
			+ ((RAD_W + 1)'(1) << (2 * B));

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial <= {1'b0, rin}) begin
					rem_q[s]  <= rin - trial[RAD_W-1:0];
					root_q[s] <= qin | (ROOT_W'(1) << B);
				end else begin
					rem_q[s]  <= rin;
					root_q[s] <= qin;
				end
			end
		end
	end

	assign root = root_q[ROOT_W-1];
endmodule

/* rtl/qcaq_lane.sv */
// ----------------------------------------------------------------------------
// qcaq_lane: per-corner lane front end
// Squared length and length of the outgoing edge, dot with the incoming edge.
// ----------------------------------------------------------------------------
module qcaq_lane import qcaq_pkg::*; (
	input  logic clk,
	input  logic en,
	input  vec_t e_cur,
	input  vec_t e_prev,
	output len_t len,
	output dot_t dot
);
	logic signed [PROD_W-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic signed [PROD_W-1:0] dpx_s1, dpy_s1, dpz_s1;
	logic [SQ_W-1:0]          sq_s2;
	dot_t                     dot_s2;
	dot_t                     dot_d [SQRT_LAT];
	rad_t                     rad;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1 <= e_cur.x * e_cur.x;
			sqy_s1 <= e_cur.y * e_cur.y;
			sqz_s1 <= e_cur.z * e_cur.z;
			dpx_s1 <= e_cur.x * e_prev.x;
			dpy_s1 <= e_cur.y * e_prev.y;
			dpz_s1 <= e_cur.z * e_prev.z;
		end
	end

	// corner cosine uses -e_prev, hence the negated sum
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2  <= SQ_W'($unsigned(sqx_s1)) + SQ_W'($unsigned(sqy_s1))
				+ SQ_W'($unsigned(sqz_s1));
			dot_s2 <= -(DOT_W'(dpx_s1) + DOT_W'(dpy_s1) + DOT_W'(dpz_s1));
		end
	end

	assign rad = RAD_W'({sq_s2, LEN_SHIFT'(0)});

	qcaq_isqrt u_len (
		.clk  (clk),
		.en   (en),
		.rad  (rad),
		.root (len)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			dot_d[0] <= dot_s2;
			for (int i = 1; i < SQRT_LAT; i++)
				dot_d[i] <= dot_d[i-1];
		end
	end

	assign dot = dot_d[SQRT_LAT-1];
endmodule

/* rtl/qcaq_cosdiv.sv */
// ----------------------------------------------------------------------------
// qcaq_cosdiv: corner cosine divider
// |dot| << 26 over the product of edge lengths, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qcaq_cosdiv import qcaq_pkg::*; (
	input  logic clk,
	input  logic en,
	input  len_t len_cur,
	input  len_t len_prev,
	input  dot_t dot,
	output cos_t cosv
);
	logic [DIV_W-1:0]    num_s1, den_s1;
	logic                neg_s1;
	logic [DOT_W-1:0]    mag;
	logic [DIV_W-1:0]    r_q   [COS_FRAC];
	logic [DIV_W-1:0]    den_q [COS_FRAC];
	logic [COS_FRAC-1:0] q_q   [COS_FRAC];
	logic                sat_q [COS_FRAC];
	logic                neg_q [COS_FRAC];
	logic [COS_W-1:0]    mag_out;
	cos_t                cos_q;

	assign mag = dot[DOT_W-1] ? $unsigned(-dot) : $unsigned(dot);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1 <= DIV_W'(len_cur) * DIV_W'(len_prev);
			num_s1 <= DIV_W'({mag, LEN_SHIFT'(0)});
			neg_s1 <= dot[DOT_W-1];
		end
	end

	for (genvar d = 0; d < COS_FRAC; d++) begin : g_div
		logic [DIV_W-1:0]    rin, din, r2;
		logic [COS_FRAC-1:0] qin;
		logic                sin, nin;

		if (d == 0) begin : g_first
			assign rin = num_s1;
			assign din = den_s1;
			assign qin = '0;
			assign sin = (den_s1 == '0) || (num_s1 >= den_s1);
			assign nin = neg_s1;
		end else begin : g_next
			assign rin = r_q[d-1];
			assign din = den_q[d-1];
			assign qin = q_q[d-1];
			assign sin = sat_q[d-1];
			assign nin = neg_q[d-1];
		end

		assign r2 = {rin[DIV_W-2:0], 1'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				den_q[d] <= din;
				sat_q[d] <= sin;
				neg_q[d] <= nin;
				if (r2 >= din) begin
					r_q[d] <= r2 - din;
					q_q[d] <= {qin[COS_FRAC-2:0], 1'b1};
				end else begin
					r_q[d] <= r2;
					q_q[d] <= {qin[COS_FRAC-2:0], 1'b0};
				end
			end
		end
	end

	assign mag_out = sat_q[COS_FRAC-1] ? (COS_W'(1) << COS_FRAC)
		: COS_W'(q_q[COS_FRAC-1]);

	always_ff @(posedge clk) begin
		if (en)
			cos_q <= neg_q[COS_FRAC-1] ? -$signed(mag_out) : $signed(mag_out);
	end

	assign cosv = cos_q;
endmodule

/* rtl/qcaq_asin.sv */
// ----------------------------------------------------------------------------
// qcaq_asin: lane merge and arcsine
// Largest corner cosine, asin via CORDIC atan2(c, sqrt(1-c^2)), rounding.
// ----------------------------------------------------------------------------
module qcaq_asin import qcaq_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  cos_t  cosv [4],
	output qual_t quality
);
	localparam rad_t ONE = RAD_W'(1) << (2 * COS_FRAC);

	cos_t                   m01, m23, cmax_s1, y_s2;
	logic signed [2*COS_W-1:0] csq;
	rad_t                   csq_s2, rad;
	len_t                   root;
	cos_t                   y_d [SQRT_LAT];
	logic signed [CX_W-1:0] x_q [CORDIC_N];
	logic signed [CX_W-1:0] yc_q [CORDIC_N];
	ang_t                   z_q [CORDIC_N];
	ang_t                   zr, qv;
	qual_t                  qual_q;

	// merge: max over the four lanes
	assign m01 = (cosv[1] > cosv[0]) ? cosv[1] : cosv[0];
	assign m23 = (cosv[3] > cosv[2]) ? cosv[3] : cosv[2];

	always_ff @(posedge clk) begin
		if (en)
			cmax_s1 <= (m23 > m01) ? m23 : m01;
	end

	assign csq = cmax_s1 * cmax_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			csq_s2 <= RAD_W'($unsigned(csq));
			y_s2   <= cmax_s1;
		end
	end

	assign rad = (csq_s2 >= ONE) ? '0 : ONE - csq_s2;

	qcaq_isqrt u_cosc (
		.clk  (clk),
		.en   (en),
		.rad  (rad),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			y_d[0] <= y_s2;
			for (int i = 1; i < SQRT_LAT; i++)
				y_d[i] <= y_d[i-1];
		end
	end

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
		logic signed [CX_W-1:0] xin, yin, dx, dy;
		ang_t                   zin;

		if (i == 0) begin : g_first
			assign xin = $signed(CX_W'(root));
			assign yin = CX_W'(y_d[SQRT_LAT-1]);
			assign zin = '0;
		end else begin : g_next
			assign xin = x_q[i-1];
			assign yin = yc_q[i-1];
			assign zin = z_q[i-1];
		end

		assign dx = yin >>> i;
		assign dy = xin >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yin[CX_W-1]) begin
					x_q[i]  <= xin + dx;
					yc_q[i] <= yin - dy;
					z_q[i]  <= zin + atan_unit(i);
				end else begin
					x_q[i]  <= xin - dx;
					yc_q[i] <= yin + dy;
					z_q[i]  <= zin - atan_unit(i);
				end
			end
		end
	end

	assign zr = z_q[CORDIC_N-1] + (ANG_W'(1) <<< (ROUND_SH - 1));
	assign qv = zr >>> ROUND_SH;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (qv > (ANG_W'(1) <<< QUAL_FRAC))
				qual_q <= QUAL_W'(1) <<< QUAL_FRAC;
			else if (qv < -(ANG_W'(1) <<< QUAL_FRAC))
				qual_q <= -(QUAL_W'(1) <<< QUAL_FRAC);
			else
				qual_q <= QUAL_W'(qv);
		end
	end

	assign quality = qual_q;
endmodule

/* rtl/quad_corner_angle_quality.sv */
// Throughput: one quad per cycle; the whole pipeline advances together and
// holds while a finished result waits on the output.
// Reset: arst_n clears the stage valid bits at once; datapath keeps its
// contents and no clearing pass is needed.
// ----------------------------------------------------------------------------
// quad_corner_angle_quality: maximum corner angle deviation quality of a quad
// Four corner lanes (edge length, dot, cosine division) run side by side; a
// merge stage takes the largest cosine and turns it into the quality word.
// ----------------------------------------------------------------------------
module quad_corner_angle_quality import qcaq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	qcaq_quad_if.sink     quad,
	qcaq_result_if.source result
);
	coord_t p [4][3];
	vec_t   e_s1 [4];
	vec_t   e_new [4];
	logic   degen_new;
	logic   en;
	logic   vld_q [PIPE_LAT];
	logic   dgn_q [PIPE_LAT];
	len_t   len [4];
	dot_t   dot [4];
	cos_t   cosv [4];
	qual_t  qual;

	// Global stall: the pipeline moves whenever the last stage is empty or
	// being taken; a stalled result therefore freezes everything behind it.
	assign en         = !vld_q[PIPE_LAT-1] || result.ready;
	assign quad.ready = en;

	assign p[0] = '{quad.corner_a_x, quad.corner_a_y, quad.corner_a_z};
	assign p[1] = '{quad.corner_b_x, quad.corner_b_y, quad.corner_b_z};
	assign p[2] = '{quad.corner_c_x, quad.corner_c_y, quad.corner_c_z};
	assign p[3] = '{quad.corner_d_x, quad.corner_d_y, quad.corner_d_z};

	// edge k runs from corner k to corner k+1
	always_comb begin
		degen_new = 1'b0;
		for (int k = 0; k < 4; k++) begin
			e_new[k].x = EDGE_W'(p[(k + 1) % 4][0]) - EDGE_W'(p[k][0]);
			e_new[k].y = EDGE_W'(p[(k + 1) % 4][1]) - EDGE_W'(p[k][1]);
			e_new[k].z = EDGE_W'(p[(k + 1) % 4][2]) - EDGE_W'(p[k][2]);
			if (e_new[k] == '0)
				degen_new = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			e_s1 <= e_new;
	end

	// valid and degenerate flag travel beside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++)
				vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= quad.valid;
			for (int i = 1; i < PIPE_LAT; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dgn_q[0] <= degen_new;
			for (int i = 1; i < PIPE_LAT; i++)
				dgn_q[i] <= dgn_q[i-1];
		end
	end

	// corner lanes: corner k sits between edge k-1 and edge k
	for (genvar k = 0; k < 4; k++) begin : g_lane
		qcaq_lane u_lane (
			.clk    (clk),
			.en     (en),
			.e_cur  (e_s1[k]),
			.e_prev (e_s1[(k + 3) % 4]),
			.len    (len[k]),
			.dot    (dot[k])
		);

		qcaq_cosdiv u_div (
			.clk      (clk),
			.en       (en),
			.len_cur  (len[k]),
			.len_prev (len[(k + 3) % 4]),
			.dot      (dot[k]),
			.cosv     (cosv[k])
		);
	end

	qcaq_asin u_asin (
		.clk     (clk),
		.en      (en),
		.cosv    (cosv),
		.quality (qual)
	);

	// a zero-length edge overrides whatever the lanes produced
	assign result.valid      = vld_q[PIPE_LAT-1];
	assign result.degenerate = dgn_q[PIPE_LAT-1];
	assign result.quality    = dgn_q[PIPE_LAT-1] ? '0 : qual;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.degenerate |-> result.quality == '0)
		else $error("degenerate word with nonzero quality");

	a_qual_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.quality <= (QUAL_W'(1) <<< QUAL_FRAC))
			&& (result.quality >= -(QUAL_W'(1) <<< QUAL_FRAC)))
		else $error("quality outside [-1, 1]");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !quad.ready)
		else $error("input taken while result stalled");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.quality))
		else $error("stalled result changed");
endmodule
